// ===== sv/urrb_pkg.sv =====
// Package for the UART receive ring buffer.
// Holds the ring geometry, field widths, command codes and error mask bit positions.
// No dependencies.
package urrb_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int BYTE_W = 8;
  localparam int ERR_W  = 4;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  localparam int ERR_FRAME    = 0;
  localparam int ERR_OVERRUN  = 1;
  localparam int ERR_NOISE    = 2;
  localparam int ERR_OVERFLOW = 3;

endpackage

// ===== sv/urrb_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// The read data is registered, so it is valid in the cycle after the address.
// No dependencies.
module urrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/urrb_ctrl.sv =====
// Pointer, error and output control for the UART receive ring buffer.
// Drives the ring RAM and holds the result item register.
// Depends on urrb_pkg.
module urrb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [urrb_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        frame_error,
  input  logic                        overrun_error,
  input  logic                        noise_error,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        no_data,
  output logic [urrb_pkg::BYTE_W-1:0] read_byte,
  output logic [urrb_pkg::ERR_W-1:0]  error_mask,
  output logic                        ram_we,
  output logic [urrb_pkg::PTR_W-1:0]  ram_waddr,
  output logic [urrb_pkg::BYTE_W-1:0] ram_wdata,
  output logic [urrb_pkg::PTR_W-1:0]  ram_raddr,
  input  logic [urrb_pkg::BYTE_W-1:0] ram_rdata
);
  import urrb_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [ERR_W-1:0] last_error;
  logic [ERR_W-1:0] rx_mask;
  logic             pending;
  logic             empty;
  logic             full;
  logic             is_read;
  logic             accept;

  assign wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign empty       = (wr_ptr == rd_ptr);
  assign full        = (wr_ptr_next == rd_ptr);
  assign is_read     = (cmd == CMD_READ);

  assign in_stall = pending | (is_read & out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    rx_mask               = '0;
    rx_mask[ERR_FRAME]    = frame_error;
    rx_mask[ERR_OVERRUN]  = overrun_error;
    rx_mask[ERR_NOISE]    = noise_error;
    rx_mask[ERR_OVERFLOW] = full;
  end

  assign ram_we    = accept & ~is_read & ~full;
  assign ram_waddr = wr_ptr_next;
  assign ram_wdata = rx_byte;
  assign ram_raddr = rd_ptr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      last_error <= '0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pending <= accept & is_read & ~empty;
      if (accept && !is_read) begin
        last_error <= rx_mask;
        if (!full) begin
          wr_ptr <= wr_ptr_next;
        end
      end
      if (accept && is_read && !empty) begin
        rd_ptr <= rd_ptr_next;
      end
      if (pending || (accept && is_read && empty)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      no_data    <= 1'b0;
      read_byte  <= ram_rdata;
      error_mask <= last_error;
    end else if (accept && is_read && empty) begin
      no_data    <= 1'b1;
      read_byte  <= '0;
      error_mask <= '0;
    end
  end

`ifndef SYNTH
  a_pending_stalls: assert property (@(posedge clk) disable iff (rst)
    pending |-> in_stall)
    else $error("input accepted while a RAM read is outstanding");

  a_pending_result: assert property (@(posedge clk) disable iff (rst)
    pending |=> out_valid && !no_data)
    else $error("RAM read did not produce a data result");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (accept && is_read && empty) |=> out_valid && no_data)
    else $error("read of an empty ring did not report no-data");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_data) |-> (read_byte == '0) && (error_mask == '0))
    else $error("no-data result carries nonzero payload");

  a_overflow_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_read && full) |=> (wr_ptr == $past(wr_ptr)) && last_error[ERR_OVERFLOW])
    else $error("receive into a full ring moved the write pointer");
`endif

endmodule

// ===== sv/uart_receive_ring_buffer_core.sv =====
// Top level of the UART receive ring buffer.
// Connects the control logic to the ring RAM.
// Depends on urrb_pkg, urrb_ram and urrb_ctrl.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  cmd, rx_byte, frame_error, overrun_error, noise_error
//   output   out_valid / out_stall  no_data, read_byte, error_mask
//
// A receive item writes the RAM directly; any item stalls while a RAM read is pending.
// A read of a nonempty ring goes through the RAM's registered read port, then the
// result register; a read of an empty ring loads the result register directly.
// Synchronous reset empties the ring at once; RAM contents are not cleared.
// A read item is stalled while the result register is full and stalled.
module uart_receive_ring_buffer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [urrb_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        frame_error,
  input  logic                        overrun_error,
  input  logic                        noise_error,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        no_data,
  output logic [urrb_pkg::BYTE_W-1:0] read_byte,
  output logic [urrb_pkg::ERR_W-1:0]  error_mask
);
  import urrb_pkg::*;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  urrb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .frame_error   (frame_error),
    .overrun_error (overrun_error),
    .noise_error   (noise_error),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .no_data       (no_data),
    .read_byte     (read_byte),
    .error_mask    (error_mask),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  urrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== tb/sv/uart_receive_ring_buffer_core_tb.sv =====
// Testbench for the UART receive ring buffer core.
// Drives receive and read items, predicts every read result and checks it field by field.
// Depends on urrb_pkg and uart_receive_ring_buffer_core.
`timescale 1ns / 100ps

module uart_receive_ring_buffer_core_tb;
  import urrb_pkg::*;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data;
    logic              fe;
    logic              oe;
    logic              ne;
  } line_item_t;

  typedef struct packed {
    logic              no_data;
    logic [BYTE_W-1:0] data;
    logic [ERR_W-1:0]  mask;
  } read_result_t;

  typedef struct packed {
    line_item_t   item;
    logic         typed;
    read_result_t want;
  } dir_row_t;

  localparam read_result_t EMPTY_READ = '{1'b1, '0, '0};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              cmd = CMD_RECEIVE;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              frame_error = 1'b0;
  logic              overrun_error = 1'b0;
  logic              noise_error = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              no_data;
  logic [BYTE_W-1:0] read_byte;
  logic [ERR_W-1:0]  error_mask;

  logic [BYTE_W-1:0] ring_copy [DEPTH];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic [ERR_W-1:0]  last_err = '0;
  read_result_t      pending_reads [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int errors = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int empty_reads = 0;
  int dropped = 0;

  dir_row_t dir_rows [15];

  uart_receive_ring_buffer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .frame_error  (frame_error),
    .overrun_error(overrun_error),
    .noise_error  (noise_error),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .no_data      (no_data),
    .read_byte    (read_byte),
    .error_mask   (error_mask)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [ERR_W-1:0] err_mask_of(logic fe, logic oe, logic ne, logic ov);
    logic [ERR_W-1:0] m;
    m = '0;
    m[ERR_FRAME]    = fe;
    m[ERR_OVERRUN]  = oe;
    m[ERR_NOISE]    = ne;
    m[ERR_OVERFLOW] = ov;
    return m;
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic line_item_t rx(logic [7:0] b, logic fe, logic oe, logic ne);
    return '{CMD_RECEIVE, b, fe, oe, ne};
  endfunction

  function automatic line_item_t rd(logic [7:0] b, logic fe, logic oe, logic ne);
    return '{CMD_READ, b, fe, oe, ne};
  endfunction

  function automatic read_result_t got(logic [7:0] b, logic [ERR_W-1:0] m);
    return '{1'b0, b, m};
  endfunction

  // Advances the ring copy by one item; returns 1 when the item yields a read result.
  function automatic logic ring_step(line_item_t it, output read_result_t res);
    logic [PTR_W-1:0] nxt;
    res = '0;
    if (it.cmd == CMD_RECEIVE) begin
      nxt = ring_next(wr_ptr);
      last_err = err_mask_of(it.fe, it.oe, it.ne, nxt == rd_ptr);
      if (nxt == rd_ptr) begin
        dropped++;
      end else begin
        wr_ptr = nxt;
        ring_copy[nxt] = it.data;
      end
      return 1'b0;
    end
    if (wr_ptr == rd_ptr) begin
      res = EMPTY_READ;
      empty_reads++;
      return 1'b1;
    end
    rd_ptr = ring_next(rd_ptr);
    res = got(ring_copy[rd_ptr], last_err);
    return 1'b1;
  endfunction

  task automatic send_item(line_item_t it, logic typed, read_result_t want);
    logic         taken;
    read_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= it.cmd;
    rx_byte       <= it.data;
    frame_error   <= it.fe;
    overrun_error <= it.oe;
    noise_error   <= it.ne;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (ring_step(it, res)) begin
      pending_reads.push_back(typed ? want : res);
    end
    items_sent++;
  endtask

  task automatic run_random(int count, int snd_idle, int rcv_stall, logic start_full);
    int         sent_here;
    int         kind;
    int         len;
    line_item_t it;
    idle_pct  = snd_idle;
    stall_pct = rcv_stall;
    sent_here = 0;
    while (sent_here < count) begin
      kind = start_full ? 0 : $urandom_range(2);
      start_full = 1'b0;
      case (kind)
        0: len = $urandom_range(DEPTH + 8, 1);
        1: len = $urandom_range(DEPTH + 4, 1);
        default: len = $urandom_range(30, 1);
      endcase
      if (len > count - sent_here) begin
        len = count - sent_here;
      end
      for (int i = 0; i < len; i++) begin
        it.cmd  = (kind == 0) ? CMD_RECEIVE : (kind == 1) ? CMD_READ : 1'($urandom_range(1));
        it.data = 8'($urandom_range(255));
        it.fe   = 1'($urandom_range(1));
        it.oe   = 1'($urandom_range(1));
        it.ne   = 1'($urandom_range(1));
        send_item(it, 1'b0, EMPTY_READ);
      end
      sent_here += len;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk) begin
    read_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: no_data %0d, read_byte %02h, error_mask %01h",
               no_data, read_byte, error_mask);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (no_data !== want.no_data) begin
          $error("no_data: expected %0d, actual %0d", want.no_data, no_data);
          errors++;
        end
        if (read_byte !== want.data) begin
          $error("read_byte: expected %02h, actual %02h", want.data, read_byte);
          errors++;
        end
        if (error_mask !== want.mask) begin
          $error("error_mask: expected %01h, actual %01h", want.mask, error_mask);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_rows = '{
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, EMPTY_READ},
      '{rx(8'h00, 1'b0, 1'b0, 1'b0), 1'b0, EMPTY_READ},
      '{rx(8'hFF, 1'b1, 1'b1, 1'b1), 1'b0, EMPTY_READ},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, got(8'h00, err_mask_of(1'b1, 1'b1, 1'b1, 1'b0))},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, got(8'hFF, err_mask_of(1'b1, 1'b1, 1'b1, 1'b0))},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, EMPTY_READ},
      '{rx(8'hA5, 1'b1, 1'b0, 1'b0), 1'b0, EMPTY_READ},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, got(8'hA5, err_mask_of(1'b1, 1'b0, 1'b0, 1'b0))},
      '{rx(8'h5A, 1'b0, 1'b1, 1'b0), 1'b0, EMPTY_READ},
      '{rx(8'h3C, 1'b0, 1'b0, 1'b1), 1'b0, EMPTY_READ},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, got(8'h5A, err_mask_of(1'b0, 1'b0, 1'b1, 1'b0))},
      '{rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b1, got(8'h3C, err_mask_of(1'b0, 1'b0, 1'b1, 1'b0))},
      '{rd(8'hFF, 1'b1, 1'b1, 1'b1), 1'b1, EMPTY_READ},
      '{rx(8'h81, 1'b1, 1'b1, 1'b1), 1'b0, EMPTY_READ},
      '{rd(8'hFF, 1'b1, 1'b1, 1'b1), 1'b1, got(8'h81, err_mask_of(1'b1, 1'b1, 1'b1, 1'b0))}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    run_random(110, 0, 0, 1'b1);
    run_random(100, 79, 0, 1'b0);
    run_random(100, 0, 79, 1'b0);
    run_random(100, 16, 16, 1'b0);

    // The result side holds off while items keep coming, so the input backs up.
    hold_req = 400;
    for (int i = 0; i < 4; i++) begin
      send_item(rx(8'(i), 1'b0, 1'b0, 1'b0), 1'b0, EMPTY_READ);
    end
    for (int i = 0; i < 4; i++) begin
      send_item(rd(8'h00, 1'b0, 1'b0, 1'b0), 1'b0, EMPTY_READ);
    end
    run_random(22, 0, 0, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);

    run_random(50, 16, 16, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d items with %0d reads checked, %0d of them on an empty ring.",
             items_sent, reads_checked, empty_reads);
    $display("%0d received bytes were dropped on a full ring.", dropped);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/urrb_pkg.sv
sv/urrb_ram.sv
sv/urrb_ctrl.sv
sv/uart_receive_ring_buffer_core.sv
tb/sv/uart_receive_ring_buffer_core_tb.sv
